### rtl/cfvg_pkg.sv
// Package for the circle fan vertex generator.
// Widths, register indexes, pipeline tag and the CORDIC arctangent table.
// No dependencies.
package cfvg_pkg;

   localparam int SEG_W          = 13;
   localparam int RADIUS_W       = 16;
   localparam int OUT_W          = 17;
   localparam int MAX_SEGMENTS   = 4096;
   localparam int DIV_STAGES     = 32;
   localparam int CORDIC_STAGES  = 16;
   localparam int ATAN_LEN       = 24;
   localparam int XY_W           = 20;
   localparam int Z_W            = 33;
   localparam int STAGE_IDX_W    = 5;
   localparam logic [31:0] PI_Q30   = 32'd3373259426;
   localparam logic [XY_W-1:0] GAIN_Q16 = XY_W'(39797);
   localparam int OUT_LIMIT      = 65535;

   typedef enum logic {
      REG_RADIUS        = 1'b0,
      REG_SEGMENT_COUNT = 1'b1
   } reg_index_type;

   // flags that ride along with each word
   typedef struct packed {
      logic vld;
      logic err;
      logic ctr;
   } tag_type;

   function automatic logic [29:0] atan_q30(input logic [STAGE_IDX_W-1:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/cfvg_div_cell.sv
// One restoring-division cell: one quotient bit per cell.
// Uses cfvg_pkg.
module cfvg_div_cell (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [cfvg_pkg::SEG_W-1:0]  seg,
   input  logic                        num_bit,
   input  logic [cfvg_pkg::SEG_W-1:0]  rem_in,
   input  logic [31:0]                 quo_in,
   output logic [cfvg_pkg::SEG_W-1:0]  rem_ff,
   output logic [31:0]                 quo_ff
);
   import cfvg_pkg::*;

   logic [SEG_W:0]   trial;
   logic             take;
   logic [SEG_W-1:0] rem_in_next;
   logic [31:0]      quo_in_next;

   always_comb begin
      trial       = {rem_in, num_bit};
      take        = (trial >= {1'b0, seg});
      rem_in_next = take ? SEG_W'(trial - {1'b0, seg}) : trial[SEG_W-1:0];
      quo_in_next = {quo_in[30:0], take};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_next;
         quo_ff <= quo_in_next;
      end
   end
endmodule

### rtl/cfvg_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation cell.
// Uses cfvg_pkg (arctangent table).
module cfvg_cordic_cell (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic [cfvg_pkg::STAGE_IDX_W-1:0]     stage_idx,
   input  logic signed [cfvg_pkg::XY_W-1:0]     x_in,
   input  logic signed [cfvg_pkg::XY_W-1:0]     y_in,
   input  logic signed [cfvg_pkg::Z_W-1:0]      z_in,
   output logic signed [cfvg_pkg::XY_W-1:0]     x_ff,
   output logic signed [cfvg_pkg::XY_W-1:0]     y_ff,
   output logic signed [cfvg_pkg::Z_W-1:0]      z_ff
);
   import cfvg_pkg::*;

   logic signed [XY_W-1:0] dx, dy, x_in_next, y_in_next;
   logic signed [Z_W-1:0]  ang, z_in_next;

   always_comb begin
      dx  = y_in >>> stage_idx;
      dy  = x_in >>> stage_idx;
      ang = $signed({{(Z_W-30){1'b0}}, atan_q30(stage_idx)});
      if (!z_in[Z_W-1]) begin
         x_in_next = x_in - dx;
         y_in_next = y_in + dy;
         z_in_next = z_in - ang;
      end else begin
         x_in_next = x_in + dx;
         y_in_next = y_in - dy;
         z_in_next = z_in + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in_next;
         y_ff <= y_in_next;
         z_ff <= z_in_next;
      end
   end
endmodule

### rtl/circle_fan_vertex_generator_top.sv
// Circle fan vertex generator: top level with config, divider and CORDIC chains.
// Uses cfvg_pkg, cfvg_div_cell, cfvg_cordic_cell.
//
// One vertex word is accepted every clock while the output is not stalled, and its result
// passes through 51 register stages: 32 divider cells for the phase, one angle multiply,
// 16 CORDIC cells, a radius multiply and the output register. The whole pipeline
// advances together, so a stalled result holds every stage until it is taken.
module circle_fan_vertex_generator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cfvg_pkg::SEG_W-1:0]        req_vertex_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [cfvg_pkg::OUT_W-1:0] rsp_x_coord,
   output logic signed [cfvg_pkg::OUT_W-1:0] rsp_y_coord,
   output logic                              rsp_index_error,
   input  logic                              csr_write_enable,
   input  logic [0:0]                        csr_index,
   input  logic [cfvg_pkg::RADIUS_W-1:0]     csr_write_data
);
   import cfvg_pkg::*;

   logic [RADIUS_W-1:0] radius_ff;
   logic [SEG_W-1:0]    seg_count_ff;
   logic [SEG_W-1:0]    seg;
   logic                adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_W'(256);
         seg_count_ff <= SEG_W'(32);
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_RADIUS:        radius_ff    <= csr_write_data;
            REG_SEGMENT_COUNT: seg_count_ff <= csr_write_data[SEG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (seg_count_ff == '0)                     seg = SEG_W'(1);
      else if (seg_count_ff > SEG_W'(MAX_SEGMENTS)) seg = SEG_W'(MAX_SEGMENTS);
      else                                        seg = seg_count_ff;
   end

   assign adv       = !rsp_valid | rsp_ready;
   assign req_ready = adv;

   // entry: classify and form the starting remainder
   tag_type          tag0;
   logic [SEG_W-1:0] km1, rem0;
   always_comb begin
      km1      = req_vertex_index - SEG_W'(1);
      tag0.vld = req_valid;
      tag0.ctr = (req_vertex_index == '0);
      tag0.err = ({1'b0, req_vertex_index} > ({1'b0, seg} + (SEG_W+1)'(1)));
      rem0     = (km1 == seg) ? '0 : km1;
   end

   // divider chain
   logic [SEG_W-1:0] rem_w [0:DIV_STAGES];
   logic [31:0]      quo_w [0:DIV_STAGES];
   tag_type          dtag_ff [1:DIV_STAGES];
   logic [SEG_W-1:0] half_seg;

   assign half_seg  = seg >> 1;
   assign rem_w[0]  = rem0;
   assign quo_w[0]  = '0;

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      logic nbit;
      if (DIV_STAGES - 1 - i < SEG_W) begin : g_b
         assign nbit = half_seg[DIV_STAGES - 1 - i];
      end else begin : g_z
         assign nbit = 1'b0;
      end
      cfvg_div_cell u_cell (
         .clock   (clock),
         .enable  (adv),
         .seg     (seg),
         .num_bit (nbit),
         .rem_in  (rem_w[i]),
         .quo_in  (quo_w[i]),
         .rem_ff  (rem_w[i+1]),
         .quo_ff  (quo_w[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= DIV_STAGES; i++) dtag_ff[i] <= '0;
      end else if (adv) begin
         dtag_ff[1] <= tag0;
         for (int i = 2; i <= DIV_STAGES; i++) dtag_ff[i] <= dtag_ff[i-1];
      end
   end

   // phase to radians
   logic [29:0]            rq;
   logic [61:0]            zprod;
   logic signed [Z_W-1:0]  z_ff;
   logic [1:0]             quad_ff;
   tag_type                ztag_ff;

   assign rq    = quo_w[DIV_STAGES][29:0];
   assign zprod = 62'(rq) * 62'(PI_Q30);

   always_ff @(posedge clock) begin
      if (adv) begin
         z_ff    <= $signed({2'b00, zprod[61:31]});
         quad_ff <= quo_w[DIV_STAGES][31:30];
      end
   end
   always_ff @(posedge clock) begin
      if (reset)     ztag_ff <= '0;
      else if (adv)  ztag_ff <= dtag_ff[DIV_STAGES];
   end

   // CORDIC chain
   logic signed [XY_W-1:0] cx_w [0:CORDIC_STAGES];
   logic signed [XY_W-1:0] cy_w [0:CORDIC_STAGES];
   logic signed [Z_W-1:0]  cz_w [0:CORDIC_STAGES];
   logic [1:0]             cquad_ff [1:CORDIC_STAGES];
   tag_type                ctag_ff  [1:CORDIC_STAGES];

   assign cx_w[0] = $signed(GAIN_Q16);
   assign cy_w[0] = '0;
   assign cz_w[0] = z_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      cfvg_cordic_cell u_cell (
         .clock     (clock),
         .enable    (adv),
         .stage_idx (STAGE_IDX_W'(i)),
         .x_in      (cx_w[i]),
         .y_in      (cy_w[i]),
         .z_in      (cz_w[i]),
         .x_ff      (cx_w[i+1]),
         .y_ff      (cy_w[i+1]),
         .z_ff      (cz_w[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cquad_ff[1] <= quad_ff;
         for (int i = 2; i <= CORDIC_STAGES; i++) cquad_ff[i] <= cquad_ff[i-1];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= CORDIC_STAGES; i++) ctag_ff[i] <= '0;
      end else if (adv) begin
         ctag_ff[1] <= ztag_ff;
         for (int i = 2; i <= CORDIC_STAGES; i++) ctag_ff[i] <= ctag_ff[i-1];
      end
   end

   // quadrant fold and radius scale
   logic signed [XY_W-1:0]   cc, ss, xc, yc;
   logic signed [XY_W+16:0]  px_ff, py_ff;
   tag_type                  ptag_ff;

   always_comb begin
      xc = cx_w[CORDIC_STAGES];
      yc = cy_w[CORDIC_STAGES];
      case (cquad_ff[CORDIC_STAGES])
         2'd1:    begin cc = -yc; ss = xc;  end
         2'd2:    begin cc = -xc; ss = -yc; end
         2'd3:    begin cc = yc;  ss = -xc; end
         default: begin cc = xc;  ss = yc;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= $signed({1'b0, radius_ff}) * cc;
         py_ff <= $signed({1'b0, radius_ff}) * ss;
      end
   end
   always_ff @(posedge clock) begin
      if (reset)     ptag_ff <= '0;
      else if (adv)  ptag_ff <= ctag_ff[CORDIC_STAGES];
   end

   // round, saturate, output register
   function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [XY_W+16:0] p);
      logic signed [XY_W+17:0] r;
      logic signed [XY_W+1:0]  v;
      logic signed [OUT_W-1:0] o;
      r = XY_W'(0) + (XY_W+18)'(p) + (XY_W+18)'(32768);
      v = (XY_W+2)'(r >>> 16);
      if (v > (XY_W+2)'(OUT_LIMIT))        o = OUT_W'(OUT_LIMIT);
      else if (v < -(XY_W+2)'(OUT_LIMIT))  o = -OUT_W'(OUT_LIMIT);
      else                                 o = OUT_W'(v);
      return o;
   endfunction

   logic                    rsp_valid_ff, rsp_err_ff;
   logic signed [OUT_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                    zero_out;

   assign zero_out = ptag_ff.err | ptag_ff.ctr;

   always_ff @(posedge clock) begin
      if (reset)     rsp_valid_ff <= 1'b0;
      else if (adv)  rsp_valid_ff <= ptag_ff.vld;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_err_ff <= ptag_ff.err;
         rsp_x_ff   <= zero_out ? '0 : round_sat(px_ff);
         rsp_y_ff   <= zero_out ? '0 : round_sat(py_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_index_error = rsp_err_ff;
   assign rsp_x_coord     = rsp_x_ff;
   assign rsp_y_coord     = rsp_y_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_x_coord == '0 && rsp_y_coord == '0)
      else $error("error word with nonzero coordinates");
   a_tag_excl: assert property (@(posedge clock) disable iff (reset)
      ptag_ff.vld |-> !(ptag_ff.err && ptag_ff.ctr))
      else $error("word flagged as both centre and error");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(ptag_ff) && $stable(ztag_ff))
      else $error("pipeline moved during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");
endmodule
